### rtl/kwl_pkg.sv
// ----------------------------------------------------------------------------
// kwl_pkg
// Types, character constants and keyword tables shared by the keyword
// token lexer modules.
// ----------------------------------------------------------------------------
package kwl_pkg;

   typedef enum logic [2:0] {
      KIND_ENSURE  = 3'd0,
      KIND_LIMIT   = 3'd1,
      KIND_ATTR    = 3'd2,
      KIND_OP      = 3'd3,
      KIND_VALUE   = 3'd4,
      KIND_END     = 3'd5,
      KIND_UNKNOWN = 3'd6
   } token_kind_type;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0]    start;
      logic [7:0]     length;
      logic [7:0]     single_char;
      logic           run_last;
   } result_type;

   localparam logic [7:0] CH_END     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_UPPER_C = 8'h43;

   localparam logic [3:0] ENSURE_LEN = 4'd6;
   localparam logic [3:0] LIMIT_LEN  = 4'd5;
   localparam logic [3:0] LOOPS_LEN  = 4'd5;
   localparam logic [3:0] CPLX_LEN   = 4'd10;

   function automatic logic is_word_char(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_LPAREN ||
             c == CH_RPAREN || c == CH_CARET;
   endfunction

   function automatic logic [7:0] ensure_char(input logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0:    r = "E";
         3'd1:    r = "N";
         3'd2:    r = "S";
         3'd3:    r = "U";
         3'd4:    r = "R";
         3'd5:    r = "E";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] limit_char(input logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0:    r = "L";
         3'd1:    r = "I";
         3'd2:    r = "M";
         3'd3:    r = "I";
         3'd4:    r = "T";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] loops_char(input logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0:    r = "L";
         3'd1:    r = "O";
         3'd2:    r = "O";
         3'd3:    r = "P";
         3'd4:    r = "S";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] cplx_char(input logic [3:0] i);
      logic [7:0] r;
      case (i)
         4'd0:    r = "C";
         4'd1:    r = "O";
         4'd2:    r = "M";
         4'd3:    r = "P";
         4'd4:    r = "L";
         4'd5:    r = "E";
         4'd6:    r = "X";
         4'd7:    r = "I";
         4'd8:    r = "T";
         4'd9:    r = "Y";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

### rtl/keyword_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// keyword_token_lexer_unit
// Streaming tokenizer: one ASCII byte per item in, tokens out.
// ----------------------------------------------------------------------------
// Usage
//   The req_ channel carries one byte of text per item; byte 0 ends a string,
//   emits an END token and restarts the offset count. The rsp_ channel gives
//   tokens in order; run_last marks the final token that a byte caused. Word
//   bytes and separators without an open word cause no token.
//   A byte is registered when accepted and lexed once the queue has room for
//   two tokens, its tokens entering a four-entry queue, so the first token is
//   offered after passing the input register and then the queue.
//   One byte is taken every cycle while the queue holds at most two tokens
//   before the lexing cycle; a byte that causes two tokens fills two queue
//   entries while the output drains one token a cycle, so only bytes that
//   cause at most one token keep up the rate of one byte a cycle.
//   When the receiver asserts rsp_stall the queue fills and req_stall rises
//   for as long as a registered byte cannot be lexed; nothing is dropped.
//   Synchronous reset empties the queue and the input register, closes any
//   open word and sets the offset to zero.
// ----------------------------------------------------------------------------
module keyword_token_lexer_unit
   import kwl_pkg::*;
#(
   parameter int MAX_LEN  = 128,
   parameter int POS_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_input_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [7:0]  rsp_token_length,
   output logic [7:0]  rsp_single_char,
   output logic        rsp_run_last
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       fire;
   logic       accept;
   logic       room2;
   logic       pop;
   logic       push0;
   logic       push1;
   result_type res0;
   result_type res1;
   result_type head;

   always_comb begin
      fire      = in_valid_ff && room2;
      req_stall = in_valid_ff && !room2;
      accept    = req_valid && !req_stall;
      pop       = rsp_valid && !rsp_stall;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_input_byte;
      end
   end

   kwl_lex_core #(
      .MAX_LEN  (MAX_LEN),
      .POS_BITS (POS_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_byte (in_byte_ff),
      .push0   (push0),
      .push1   (push1),
      .res0    (res0),
      .res1    (res1)
   );

   kwl_res_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push0     (push0),
      .push1     (push1),
      .din0      (res0),
      .din1      (res1),
      .pop       (pop),
      .head      (head),
      .not_empty (rsp_valid),
      .room2     (room2)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.length;
   assign rsp_single_char  = head.single_char;
   assign rsp_run_last     = head.run_last;

   a_push_needs_fire : assert property (@(posedge clock) disable iff (reset)
      push0 |-> fire)
      else $error("result pushed without a byte being lexed");

   a_second_needs_first : assert property (@(posedge clock) disable iff (reset)
      push1 |-> (push0 && !res0.run_last && res1.run_last))
      else $error("two results pushed with wrong order or run_last marking");

   a_single_is_last : assert property (@(posedge clock) disable iff (reset)
      (push0 && !push1) |-> res0.run_last)
      else $error("single result of a byte not marked as last");

   a_push_shows_valid : assert property (@(posedge clock) disable iff (reset)
      push0 |=> rsp_valid)
      else $error("queue empty after a result was pushed");

endmodule

### rtl/kwl_lex_core.sv
// ----------------------------------------------------------------------------
// kwl_lex_core
// Lexer state and per-byte token logic: takes one byte when fire is high and
// produces up to two results (a closed word, then a one-byte token).
// ----------------------------------------------------------------------------
module kwl_lex_core
   import kwl_pkg::*;
#(
   parameter int MAX_LEN  = 128,
   parameter int POS_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] in_byte,
   output logic       push0,
   output logic       push1,
   output result_type res0,
   output result_type res1
);

   localparam int LEN_BITS = $clog2(MAX_LEN + 1);

   logic                in_word_ff;
   logic [POS_BITS-1:0] word_start_ff;
   logic [LEN_BITS-1:0] word_len_ff;
   logic [POS_BITS-1:0] pos_ff;
   logic                ens_alive_ff;
   logic                lim_alive_ff;
   logic                loops_alive_ff;
   logic [3:0]          cplx_prog_ff;
   logic                cplx_found_ff;

   logic [LEN_BITS-1:0] word_len_in;
   logic                ens_alive_in;
   logic                lim_alive_in;
   logic                loops_alive_in;
   logic [3:0]          cplx_prog_in;
   logic                cplx_found_in;

   logic                eff_ens;
   logic                eff_lim;
   logic                eff_loops;
   logic [3:0]          eff_prog;
   logic                eff_found;
   logic [LEN_BITS-1:0] eff_len;

   logic                is_word;
   logic                is_sep;
   logic                is_op;
   logic                is_end;
   logic                close_v;
   logic                tok_v;
   token_kind_type      close_kind;
   token_kind_type      tok_kind;
   logic [31:0]         start_wide;
   logic [31:0]         pos_wide;
   logic [31:0]         len_wide;
   result_type          close_res;
   result_type          tok_res;

   // A word byte that opens a word starts from a freshly cleared match state.
   always_comb begin
      eff_ens   = in_word_ff ? ens_alive_ff   : 1'b1;
      eff_lim   = in_word_ff ? lim_alive_ff   : 1'b1;
      eff_loops = in_word_ff ? loops_alive_ff : 1'b1;
      eff_prog  = in_word_ff ? cplx_prog_ff   : 4'd0;
      eff_found = in_word_ff ? cplx_found_ff  : 1'b0;
      eff_len   = in_word_ff ? word_len_ff    : '0;
   end

   always_comb begin
      ens_alive_in   = eff_ens && (eff_len < LEN_BITS'(ENSURE_LEN)) &&
                       (in_byte == ensure_char(eff_len[2:0]));
      lim_alive_in   = eff_lim && (eff_len < LEN_BITS'(LIMIT_LEN)) &&
                       (in_byte == limit_char(eff_len[2:0]));
      loops_alive_in = eff_loops && (eff_len < LEN_BITS'(LOOPS_LEN)) &&
                       (in_byte == loops_char(eff_len[2:0]));
      cplx_prog_in   = eff_prog;
      cplx_found_in  = eff_found;
      // The search word has no repeated letters, so a mismatch restarts at C.
      if (!eff_found) begin
         if (eff_prog < CPLX_LEN && cplx_char(eff_prog) == in_byte) begin
            cplx_prog_in = eff_prog + 4'd1;
         end else begin
            cplx_prog_in = (in_byte == CH_UPPER_C) ? 4'd1 : 4'd0;
         end
         cplx_found_in = (cplx_prog_in >= CPLX_LEN);
      end
      if (eff_len < LEN_BITS'(MAX_LEN)) begin
         word_len_in = eff_len + LEN_BITS'(1);
      end else begin
         word_len_in = eff_len;
      end
   end

   always_comb begin
      is_word = is_word_char(in_byte);
      is_end  = (in_byte == CH_END);
      is_sep  = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_NEWLINE);
      is_op   = (in_byte == CH_LT) || (in_byte == CH_GT) || (in_byte == CH_EQ);
      close_v = !is_word && in_word_ff;
      tok_v   = !is_word && !is_sep;

      if (ens_alive_ff && word_len_ff == LEN_BITS'(ENSURE_LEN)) begin
         close_kind = KIND_ENSURE;
      end else if (lim_alive_ff && word_len_ff == LEN_BITS'(LIMIT_LEN)) begin
         close_kind = KIND_LIMIT;
      end else if (cplx_found_ff ||
                   (loops_alive_ff && word_len_ff == LEN_BITS'(LOOPS_LEN))) begin
         close_kind = KIND_ATTR;
      end else begin
         close_kind = KIND_VALUE;
      end

      if (is_end) begin
         tok_kind = KIND_END;
      end else if (is_op) begin
         tok_kind = KIND_OP;
      end else begin
         tok_kind = KIND_UNKNOWN;
      end

      start_wide = 32'(word_start_ff);
      pos_wide   = 32'(pos_ff);
      len_wide   = 32'(word_len_ff);

      close_res.kind        = close_kind;
      close_res.start       = start_wide[15:0];
      close_res.length      = len_wide[7:0];
      close_res.single_char = 8'h00;
      close_res.run_last    = !tok_v;

      tok_res.kind        = tok_kind;
      tok_res.start       = pos_wide[15:0];
      tok_res.length      = is_end ? 8'd0 : 8'd1;
      tok_res.single_char = is_end ? 8'h00 : in_byte;
      tok_res.run_last    = 1'b1;

      res0  = close_v ? close_res : tok_res;
      res1  = tok_res;
      push0 = fire && (close_v || tok_v);
      push1 = fire && close_v && tok_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff <= 1'b0;
         pos_ff     <= '0;
      end else if (fire) begin
         if (is_word) begin
            in_word_ff <= 1'b1;
            pos_ff     <= pos_ff + POS_BITS'(1);
         end else begin
            in_word_ff <= 1'b0;
            pos_ff     <= is_end ? '0 : pos_ff + POS_BITS'(1);
         end
      end
   end

   // Word payload is only read while a word is open, so it needs no reset.
   always_ff @(posedge clock) begin
      if (fire && is_word) begin
         if (!in_word_ff) begin
            word_start_ff <= pos_ff;
         end
         word_len_ff    <= word_len_in;
         ens_alive_ff   <= ens_alive_in;
         lim_alive_ff   <= lim_alive_in;
         loops_alive_ff <= loops_alive_in;
         cplx_prog_ff   <= cplx_prog_in;
         cplx_found_ff  <= cplx_found_in;
      end
   end

endmodule

### rtl/kwl_res_fifo.sv
// ----------------------------------------------------------------------------
// kwl_res_fifo
// Four-entry result queue that takes up to two results a cycle and gives
// one, decoupling the lexer from a stalling receiver.
// ----------------------------------------------------------------------------
module kwl_res_fifo
   import kwl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push0,
   input  logic       push1,
   input  result_type din0,
   input  result_type din1,
   input  logic       pop,
   output result_type head,
   output logic       not_empty,
   output logic       room2
);

   result_type mem_ff [4];
   logic [1:0] wr_ptr_ff;
   logic [1:0] rd_ptr_ff;
   logic [2:0] count_ff;
   logic [1:0] wr_ptr_in;
   logic [1:0] rd_ptr_in;
   logic [2:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + {1'b0, push0} + {1'b0, push1};
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {2'b00, push0} + {2'b00, push1} - {2'b00, pop};
      head      = mem_ff[rd_ptr_ff];
      not_empty = (count_ff != 3'd0);
      room2     = (count_ff <= 3'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[wr_ptr_ff] <= din0;
      end
      if (push1) begin
         mem_ff[wr_ptr_ff + 2'd1] <= din1;
      end
   end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for keyword_token_lexer_unit. Directed and random
// text is fed in one byte per item, a behavioural lexer predicts the tokens,
// and every token the unit emits is compared in order, field by field.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kwl_pkg::*;

   localparam int WORD_LIMIT   = 128;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 50;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_input_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [7:0]  rsp_token_length;
   logic [7:0]  rsp_single_char;
   logic        rsp_run_last;

   keyword_token_lexer_unit #(
      .MAX_LEN  (WORD_LIMIT),
      .POS_BITS (16)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_input_byte   (req_input_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_single_char  (rsp_single_char),
      .rsp_run_last     (rsp_run_last)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Text waiting to be sent and tokens waiting to be seen.
   logic [7:0] byte_queue[$];
   result_type expected_tokens[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int tokens_seen   = 0;
   logic hold_toggle = 1'b0;
   logic hold_seen   = 1'b0;
   int   hold_left   = 0;

   // Lexer state of the predictor.
   logic        word_open  = 1'b0;
   logic [15:0] word_first = '0;
   int unsigned word_count = 0;
   logic [47:0] word_head  = '0;
   logic [79:0] word_tail  = '0;
   logic        cplx_seen  = 1'b0;
   logic [15:0] lex_pos    = '0;

   string keyword_forms[16] = '{"ENSURE", "LIMIT", "LOOPS", "COMPLEXITY", "Ensure",
                                "LIMIt", "loops", "COMPLEXIT", "ENSUR", "LIMITS",
                                "ENSUREE", "CCOMPLEXITY", "COMPLEXCOMPLEXITY",
                                "x_COMPLEXITY^9", "COMPLEXITYCOMPLEXITY", "LOOP"};

   function automatic logic word_byte(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_LPAREN ||
             c == CH_RPAREN || c == CH_CARET;
   endfunction

   function automatic result_type word_token();
      result_type t;
      t = '0;
      if (word_count == 6 && word_head == "ENSURE") begin
         t.kind = KIND_ENSURE;
      end else if (word_count == 5 && word_head[39:0] == "LIMIT") begin
         t.kind = KIND_LIMIT;
      end else if (cplx_seen || (word_count == 5 && word_head[39:0] == "LOOPS")) begin
         t.kind = KIND_ATTR;
      end else begin
         t.kind = KIND_VALUE;
      end
      t.start  = word_first;
      t.length = 8'(word_count);
      return t;
   endfunction

   // Advances the predictor by one byte and queues the tokens it causes.
   task automatic lex_byte(input logic [7:0] c);
      result_type toks[2];
      int n;
      n = 0;
      if (word_byte(c)) begin
         if (!word_open) begin
            word_open  = 1'b1;
            word_first = lex_pos;
            word_count = 0;
            word_head  = '0;
            word_tail  = '0;
            cplx_seen  = 1'b0;
         end
         if (word_count < 6) word_head = {word_head[39:0], c};
         // The window slides over the whole word, so a match past the
         // saturated length still counts.
         word_tail = {word_tail[71:0], c};
         if (word_tail == "COMPLEXITY") cplx_seen = 1'b1;
         if (word_count < WORD_LIMIT) word_count++;
         lex_pos++;
      end else begin
         if (word_open) begin
            toks[n] = word_token();
            n++;
            word_open = 1'b0;
         end
         if (c == CH_END) begin
            toks[n] = '0;
            toks[n].kind  = KIND_END;
            toks[n].start = lex_pos;
            n++;
            lex_pos = '0;
         end else begin
            if (!(c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE)) begin
               toks[n] = '0;
               if (c == CH_LT || c == CH_GT || c == CH_EQ) begin
                  toks[n].kind = KIND_OP;
               end else begin
                  toks[n].kind = KIND_UNKNOWN;
               end
               toks[n].start       = lex_pos;
               toks[n].length      = 8'd1;
               toks[n].single_char = c;
               n++;
            end
            lex_pos++;
         end
      end
      for (int i = 0; i < n; i++) begin
         if (i == n - 1) toks[i].run_last = 1'b1;
         expected_tokens.push_back(toks[i]);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t token %0d: %s is %0h, expected %0h", $time, tokens_seen, what,
                  got, want);
   endtask

   // Sender: holds each item until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) lex_byte(req_input_byte);
         if (!req_valid || !req_stall) begin
            if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid      <= 1'b1;
               req_input_byte <= byte_queue.pop_front();
            end else begin
               req_valid      <= 1'b0;
               req_input_byte <= 8'($urandom);
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever the toggle flips.
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : token_check
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            report_mismatch("unexpected token, kind", 16'(rsp_token_kind), 16'hFFFF);
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_token_kind !== want.kind)
               report_mismatch("kind", 16'(rsp_token_kind), 16'(want.kind));
            if (rsp_token_start !== want.start)
               report_mismatch("start", rsp_token_start, want.start);
            if (rsp_token_length !== want.length)
               report_mismatch("length", 16'(rsp_token_length), 16'(want.length));
            if (rsp_single_char !== want.single_char)
               report_mismatch("char", 16'(rsp_single_char), 16'(want.single_char));
            if (rsp_run_last !== want.run_last)
               report_mismatch("run_last", 16'(rsp_run_last), 16'(want.run_last));
         end
         tokens_seen++;
      end
   end

   function automatic logic [7:0] rand_word_byte();
      int unsigned k;
      k = $urandom_range(0, 65);
      if (k < 26) return 8'(8'h41 + k);
      if (k < 52) return 8'(8'h61 + k - 26);
      if (k < 62) return 8'(8'h30 + k - 52);
      case (k)
         62:      return CH_UNDER;
         63:      return CH_LPAREN;
         64:      return CH_RPAREN;
         default: return CH_CARET;
      endcase
   endfunction

   function automatic logic [7:0] rand_unknown_byte();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(1, 255));
      end while (word_byte(c) || c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE ||
                 c == CH_LT || c == CH_GT || c == CH_EQ);
      return c;
   endfunction

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
   endtask

   task automatic push_word(input int len);
      repeat (len) byte_queue.push_back(rand_word_byte());
   endtask

   task automatic push_break();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)      byte_queue.push_back(CH_SPACE);
      else if (r < 50) byte_queue.push_back(CH_TAB);
      else if (r < 58) byte_queue.push_back(CH_NEWLINE);
      else if (r < 62) byte_queue.push_back(CH_LT);
      else if (r < 66) byte_queue.push_back(CH_GT);
      else if (r < 70) byte_queue.push_back(CH_EQ);
      else if (r < 85) byte_queue.push_back(rand_unknown_byte());
      else             byte_queue.push_back(CH_END);
   endtask

   // Mostly words and keywords closed by separators, with some raw noise.
   task automatic push_random_text(input int n_bytes);
      int target;
      int r;
      target = byte_queue.size() + n_bytes;
      while (byte_queue.size() < target) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            byte_queue.push_back(8'($urandom_range(0, 255)));
         end else if (r < 30) begin
            if ($urandom_range(0, 4) == 0) push_word($urandom_range(1, 3));
            push_text(keyword_forms[$urandom_range(0, 15)]);
            if ($urandom_range(0, 4) == 0) push_word($urandom_range(1, 3));
            push_break();
         end else if (r < 82) begin
            push_word($urandom_range(1, 12));
            push_break();
         end else if (r < 85) begin
            push_word($urandom_range(120, 140));
            push_break();
         end else begin
            push_break();
         end
      end
   endtask

   task automatic wait_drained();
      while (byte_queue.size() != 0 || req_valid || expected_tokens.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 33;
      recv_idle_pct = 69;
      push_text("ENSURE LIMIT<LOOPS=");
      byte_queue.push_back(8'hFF);
      push_text("a");
      byte_queue.push_back(CH_END);
      byte_queue.push_back(CH_END);
      push_text("\t>");
      push_random_text(430);
      hold_toggle = ~hold_toggle;
      wait_drained();

      send_idle_pct = 69;
      recv_idle_pct = 33;
      push_random_text(450);
      wait_drained();

      // No idling: a long hold-off fills the unit.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_random_text(450);
      hold_toggle = ~hold_toggle;
      wait_drained();

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
